// ===== rtl/septet_pack_unpack_macros.svh =====
// ----------------------------------------------------------------------------
// Septet pack/unpack assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef SEPTET_PACK_UNPACK_MACROS_SVH
`define SEPTET_PACK_UNPACK_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define SPU_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("septet_pack_unpack assertion failed");

// same, on the block's own clock and reset
`define SPU_ASSERT(lbl, prop) \
  `SPU_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/spu_pkg.sv =====
// ----------------------------------------------------------------------------
// Septet pack/unpack package
// Payload types, queue entry type and shared constants.
// ----------------------------------------------------------------------------
package spu_pkg;

  localparam logic [6:0] SeptetMask = 7'h7f;
  localparam logic [2:0] SeptetBits = 3'd7;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic {
    DirPack   = 1'b0,
    DirUnpack = 1'b1
  } dir_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;
  } out_item_t;

  // one queue entry holds all results of one input beat
  typedef struct packed {
    logic [7:0] val0;
    logic [7:0] val1;
    logic       two;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/spu_front.sv =====
// ----------------------------------------------------------------------------
// Septet pack/unpack front end
// Accepts input beats, holds position and leftover state, forms the results
// of each beat and writes them as one queue entry.
// ----------------------------------------------------------------------------
module spu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_direction_i,
  input  logic              accept_i,
  input  spu_pkg::in_item_t in_item_i,
  output logic              q_we_o,
  output spu_pkg::entry_t   q_entry_o
);
  import spu_pkg::*;

  dir_e       direction_q;
  logic [2:0] pos_q, pos_d;
  logic [6:0] lo_q, lo_d;

  logic [6:0]  c;
  logic [15:0] pk_wide;
  logic [7:0]  pk_main;
  logic [6:0]  pk_lo;
  logic [2:0]  pk_pos;
  logic        pk_flush;
  logic [2:0]  up_p;
  logic [6:0]  up_l;
  logic [14:0] up_wide;
  logic [7:0]  up_shr;
  logic [6:0]  up_lo;
  logic [2:0]  up_p1;

  always_comb begin
    c        = in_item_i.in_byte[6:0];
    // pack
    pk_wide  = {9'b0, c} << (4'd8 - {1'b0, pos_q});
    pk_main  = pk_wide[7:0] | {1'b0, lo_q};
    pk_lo    = (pos_q == 3'd0) ? c : ((c >> pos_q) & SeptetMask);
    pk_pos   = pos_q + 3'd1;
    pk_flush = in_item_i.last_item && (pk_pos != 3'd0);
    // unpack, position seven treated as zero
    up_p     = (pos_q >= SeptetBits) ? 3'd0 : pos_q;
    up_l     = (pos_q >= SeptetBits) ? 7'd0 : lo_q;
    up_wide  = {7'b0, in_item_i.in_byte} << up_p;
    up_shr   = in_item_i.in_byte >> (SeptetBits - up_p);
    up_lo    = up_shr[6:0];
    up_p1    = up_p + 3'd1;
  end

  always_comb begin
    pos_d     = pos_q;
    lo_d      = lo_q;
    q_we_o    = 1'b0;
    q_entry_o = '0;
    q_entry_o.last = in_item_i.last_item;
    unique case (direction_q)
      DirPack: begin
        pos_d = pk_pos;
        lo_d  = pk_lo;
        if (pos_q != 3'd0) begin
          q_we_o         = 1'b1;
          q_entry_o.val0 = pk_main;
          q_entry_o.val1 = {1'b0, pk_lo};
          q_entry_o.two  = pk_flush;
        end else if (pk_flush) begin
          q_we_o         = 1'b1;
          q_entry_o.val0 = {1'b0, pk_lo};
        end
      end
      DirUnpack: begin
        q_we_o         = 1'b1;
        q_entry_o.val0 = {1'b0, up_wide[6:0] | up_l};
        q_entry_o.val1 = {1'b0, up_lo};
        if (up_p1 == SeptetBits) begin
          q_entry_o.two = 1'b1;
          pos_d         = 3'd0;
          lo_d          = 7'd0;
        end else begin
          pos_d = up_p1;
          lo_d  = up_lo;
        end
      end
      default: ;
    endcase
    if (in_item_i.last_item) begin
      pos_d = 3'd0;
      lo_d  = 7'd0;
    end
    if (!accept_i) begin
      q_we_o = 1'b0;
      pos_d  = pos_q;
      lo_d   = lo_q;
    end
    if (cfg_we_i) begin
      pos_d = 3'd0;
      lo_d  = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DirPack;
      pos_q       <= 3'd0;
      lo_q        <= 7'd0;
    end else begin
      if (cfg_we_i) begin
        direction_q <= dir_e'(cfg_direction_i);
      end
      pos_q <= pos_d;
      lo_q  <= lo_d;
    end
  end

endmodule

// ===== rtl/spu_queue.sv =====
// ----------------------------------------------------------------------------
// Septet pack/unpack entry queue
// Small register queue between front end and back end.
// ----------------------------------------------------------------------------
module spu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  spu_pkg::entry_t  wdata_i,
  input  logic             re_i,
  output spu_pkg::entry_t  rdata_o,
  output spu_pkg::q_stat_t stat_o
);
  import spu_pkg::*;

  entry_t        mem_q [QDepth];
  logic [QAw:0]  wptr_q, rptr_q;

  assign rdata_o      = mem_q[rptr_q[QAw-1:0]];
  assign stat_o.empty = (wptr_q == rptr_q);
  assign stat_o.full  = (wptr_q[QAw-1:0] == rptr_q[QAw-1:0]) &&
                        (wptr_q[QAw] != rptr_q[QAw]);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wptr_q[QAw-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (we_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (re_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spu_back.sv =====
// ----------------------------------------------------------------------------
// Septet pack/unpack back end
// Drains queue entries, one result beat per pop, and marks run and
// message ends.
// ----------------------------------------------------------------------------
module spu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spu_pkg::entry_t    entry_i,
  input  spu_pkg::q_stat_t   stat_i,
  input  logic               pop_i,
  output logic               q_re_o,
  output logic               empty_o,
  output spu_pkg::out_item_t out_item_o
);
  import spu_pkg::*;

  logic sub_q, sub_d;
  logic take;
  logic final_one;

  assign empty_o   = stat_i.empty;
  assign take      = pop_i && !stat_i.empty;
  assign final_one = sub_q || !entry_i.two;
  assign q_re_o    = take && final_one;

  always_comb begin
    out_item_o.out_byte    = sub_q ? entry_i.val1 : entry_i.val0;
    out_item_o.run_end     = final_one;
    out_item_o.message_end = final_one && entry_i.last;
    sub_d = sub_q;
    if (take) begin
      sub_d = !final_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

// ===== rtl/septet_pack_unpack.sv =====
// ----------------------------------------------------------------------------
// Septet pack/unpack
// GSM 7-bit septet packer and unpacker with a queue between front and back end.
// ----------------------------------------------------------------------------
// One input beat is taken every cycle while full_o is low; its results are
// registered in the queue and show on the output once older entries have
// been popped. Each beat yields zero, one or two results, and results leave
// one per pop, so a beat with two results takes two pops. A four-entry queue
// of per-beat results between the front end and the back end sets how far
// input may run ahead of output. The direction register is written through
// the cfg channel (always ready); a write also restarts the message state.
module septet_pack_unpack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_direction_i,
  input  logic               push_i,
  output logic               full_o,
  input  spu_pkg::in_item_t  in_item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output spu_pkg::out_item_t out_item_o
);
  import spu_pkg::*;

  logic    q_we, q_re;
  entry_t  q_wdata, q_rdata;
  q_stat_t q_stat;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_stat.full;

  spu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_direction_i (cfg_direction_i),
    .accept_i        (push_i && !q_stat.full),
    .in_item_i       (in_item_i),
    .q_we_o          (q_we),
    .q_entry_o       (q_wdata)
  );

  spu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (q_we),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  spu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (q_rdata),
    .stat_i     (q_stat),
    .pop_i      (pop_i),
    .q_re_o     (q_re),
    .empty_o    (empty_o),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/spu_checker.sv =====
// ----------------------------------------------------------------------------
// Septet pack/unpack checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "septet_pack_unpack_macros.svh"

module spu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               cfg_direction_i,
  input logic               push_i,
  input logic               full_o,
  input spu_pkg::in_item_t  in_item_i,
  input logic               empty_o,
  input logic               pop_i,
  input spu_pkg::out_item_t out_item_o
);
  import spu_pkg::*;

  // message end only on the final result of a beat
  `SPU_ASSERT(a_msg_end_run_end, (!empty_o && out_item_o.message_end) |-> out_item_o.run_end)
  // nothing appears without an accepted input beat
  `SPU_ASSERT(a_no_invent, (empty_o && !(push_i && !full_o)) |=> empty_o)
  // second result of a beat follows right behind the first
  `SPU_ASSERT(a_pair_follows, (!empty_o && pop_i && !out_item_o.run_end) |=> !empty_o)
  // a waiting result holds until popped
  `SPU_ASSERT(a_hold, (!empty_o && !pop_i) |=> (!empty_o && $stable(out_item_o)))

endmodule

bind septet_pack_unpack spu_checker u_spu_checker (.*);

// ===== sim/spu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Septet pack/unpack checker
// Watches the cfg, input and result channels of the block and keeps its own
// copy of the direction, position and leftover state. It predicts the
// results of every accepted input beat, then compares each popped result
// field by field with the oldest prediction and counts mismatches.
// ----------------------------------------------------------------------------
module spu_tb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_direction_i,
  input  logic               push_i,
  input  logic               full_i,
  input  spu_pkg::in_item_t  in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  spu_pkg::out_item_t out_item_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  import spu_pkg::*;

  dir_e        mode_q;
  logic [2:0]  pos_q;
  logic [6:0]  carry_q;
  out_item_t   due_results[$];
  int unsigned err_cnt = 0;

  assign errors_o = err_cnt;

  task automatic flag_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic codec_step(input in_item_t item);
    logic [7:0]  vals [2];
    logic [15:0] wide;
    logic [2:0]  p;
    int          n;
    out_item_t   r;
    n = 0;
    if (mode_q == DirPack) begin
      if (pos_q == 3'd0) begin
        carry_q = item.in_byte[6:0];
      end else begin
        wide = {9'd0, item.in_byte[6:0]} << (4'd8 - {1'b0, pos_q});
        vals[n] = wide[7:0] | {1'b0, carry_q};
        n++;
        carry_q = item.in_byte[6:0] >> pos_q;
      end
      pos_q = pos_q + 3'd1;
      if (item.last_item) begin
        // flush partial octet at end of message
        if (pos_q != 3'd0) begin
          vals[n] = {1'b0, carry_q};
          n++;
        end
        pos_q   = 3'd0;
        carry_q = 7'd0;
      end
    end else begin
      p = pos_q;
      if (p == SeptetBits) begin
        p       = 3'd0;
        carry_q = 7'd0;
      end
      wide = {8'd0, item.in_byte} << p;
      vals[n] = {1'b0, wide[6:0] | carry_q};
      n++;
      wide = {8'd0, item.in_byte} >> (SeptetBits - p);
      carry_q = wide[6:0];
      p = p + 3'd1;
      if (p == SeptetBits) begin
        // seventh octet: leftover is a whole septet
        vals[n] = {1'b0, carry_q};
        n++;
        p       = 3'd0;
        carry_q = 7'd0;
      end
      pos_q = p;
      if (item.last_item) begin
        pos_q   = 3'd0;
        carry_q = 7'd0;
      end
    end
    for (int k = 0; k < n; k++) begin
      r.out_byte    = vals[k];
      r.run_end     = (k == n - 1);
      r.message_end = (k == n - 1) && item.last_item;
      due_results.push_back(r);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      flag_error($sformatf("unexpected result byte %02h", got.out_byte));
    end else begin
      want = due_results.pop_front();
      if (got.out_byte !== want.out_byte)
        flag_error($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      if (got.run_end !== want.run_end)
        flag_error($sformatf("run_end got %b want %b", got.run_end, want.run_end));
      if (got.message_end !== want.message_end)
        flag_error($sformatf("message_end got %b want %b",
                             got.message_end, want.message_end));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  = DirPack;
      pos_q   = 3'd0;
      carry_q = 7'd0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q  = dir_e'(cfg_direction_i);
        pos_q   = 3'd0;
        carry_q = 7'd0;
      end
      if (push_i && !full_i) codec_step(in_item_i);
      if (pop_i && !empty_i) check_result(out_item_i);
      pending_o <= due_results.size();
    end
  end

endmodule

// ===== sim/tb_septet_pack_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Septet pack/unpack testbench
// Drives directed and random messages in both directions through the block,
// with random stalls on both queue sides and direction changes between
// phases. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_septet_pack_unpack;
  import spu_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_dir   = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_item_t    in_item   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_item_t   out_item;
  int unsigned pending;
  int unsigned errors;
  int unsigned cycles    = 0;
  bit          quiet     = 1'b0;

  septet_pack_unpack uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_direction_i(cfg_dir),
    .push_i         (push),
    .full_o         (full),
    .in_item_i      (in_item),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_item_o     (out_item)
  );

  spu_tb_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_direction_i(cfg_dir),
    .push_i         (push),
    .full_i         (full),
    .in_item_i      (in_item),
    .empty_i        (empty),
    .pop_i          (pop),
    .out_item_i     (out_item),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** septet_pack_unpack: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic lst, input bit may_idle);
    push    <= 1'b1;
    in_item <= in_item_t'{in_byte: b, last_item: lst};
    @(posedge clk);
    while (full) @(posedge clk);
    if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_direction(input dir_e d);
    cfg_valid <= 1'b1;
    cfg_dir   <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int unsigned len, input bit noisy, input bit may_idle);
    logic lst;
    for (int unsigned k = 1; k <= len; k++) begin
      lst = noisy ? ($urandom_range(0, 3) == 0) : (k == len);
      send_beat(8'($urandom_range(0, 255)), lst, may_idle);
    end
  endtask

  task automatic run_phase(input dir_e d, input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          noisy;
    bit          lively;
    bit          first;
    wait_idle();
    write_direction(d);
    sent  = 0;
    first = 1'b1;
    while (sent < n_items) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
      noisy  = ($urandom_range(0, 6) == 0);
      lively = ($urandom_range(0, 3) != 0);
      send_message(len, noisy, lively);
      sent += len;
      // hold the sender until the output side has drained
      if (first || $urandom_range(0, 29) == 0) wait_idle();
      first = 1'b0;
    end
  endtask

  initial begin
    pop <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic [7:0] pack_bytes [12];
    bit         pack_last  [12];
    logic [7:0] unpack_bytes [11];
    bit         unpack_last  [11];
    // full group of eight, single char, short message with flush
    pack_bytes   = '{8'h7f, 8'h00, 8'hff, 8'h80, 8'h55, 8'h2a, 8'h7f, 8'h01,
                     8'h41, 8'h7f, 8'hff, 8'h01};
    pack_last    = '{0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1};
    // seven octets ending on the double result, single octet, short message
    unpack_bytes = '{8'hff, 8'h00, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'haa, 8'h55,
                     8'hff, 8'hff, 8'h80};
    unpack_last  = '{0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_direction(DirPack);
    foreach (pack_bytes[i]) send_beat(pack_bytes[i], pack_last[i], 1'b1);
    wait_idle();
    write_direction(DirUnpack);
    foreach (unpack_bytes[i]) send_beat(unpack_bytes[i], unpack_last[i], 1'b1);

    run_phase(DirPack, 80);
    run_phase(DirUnpack, 80);
    run_phase(DirUnpack, 80);
    run_phase(DirPack, 80);
    run_phase(DirUnpack, 80);
    quiet = 1'b1;
    run_phase(DirPack, 90);
    wait_idle();

    if (errors == 0) begin
      $display("** septet_pack_unpack: PASSED **");
    end else begin
      $display("** septet_pack_unpack: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spu_pkg.sv
rtl/spu_front.sv
rtl/spu_queue.sv
rtl/spu_back.sv
rtl/septet_pack_unpack.sv
rtl/spu_checker.sv
sim/spu_checker.sv
sim/tb_septet_pack_unpack.sv
